@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled during reset.
`define CHK_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/core/gn2d_pkg.sv @@
// Package for the 2D gradient noise block: payload types, constants and commands.
// No dependencies.
package gn2d_pkg;
  localparam int GridWDefault = 64;
  localparam int GridHDefault = 64;
  localparam int GradW = 32;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic [6:0]         table_col;
    logic [6:0]         table_row;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic signed [17:0] noise;
    logic               in_range;
    logic               load_done;
  } out_item_t;
endpackage

@@ rtl/core/gn2d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gn2d_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/core/gn2d_fade.sv @@
// Quintic fade pipeline: f -> 6f^5 - 15f^4 + 10f^3 in Q0.16.
// Depends on nothing; four registered stages, advanced by en.
module gn2d_fade (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] f,
  output logic [16:0] s
);
  logic [15:0] f1, f2, f3;
  logic [19:0] s1;
  logic [17:0] s2, s3;
  logic [35:0] inner;
  logic [35:0] p1, p2, p3;

  // The inner polynomial is always positive and at most 10 * 2^32.
  assign inner = 36'd10 * 36'h1_0000_0000 + 36'd6 * ({20'd0, f} * {20'd0, f})
                 - 36'd15 * {4'd0, f, 16'd0};
  assign p1 = {16'd0, s1} * {20'd0, f1};
  assign p2 = {18'd0, s2} * {20'd0, f2};
  assign p3 = {18'd0, s3} * {20'd0, f3};

  // One multiply per stage, truncating each product by 16 bits. The first partial
  // product peaks near 2.01 and the second near 1.2, so 18 bits hold both.
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= inner[35:16];
      f1 <= f;
      s2 <= p1[33:16];
      f2 <= f1;
      s3 <= p2[33:16];
      f3 <= f2;
      s  <= p3[32:16];
    end
  end
endmodule

@@ rtl/core/gn2d_table.sv @@
// Gradient table: four RAM banks split by lattice column and row parity, so the
// four corners of a cell are read together. Depends on gn2d_pkg and gn2d_ram.
module gn2d_table #(
  parameter int GridW = gn2d_pkg::GridWDefault,
  parameter int GridH = gn2d_pkg::GridHDefault
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [6:0]               wcol,
  input  logic [6:0]               wrow,
  input  logic [gn2d_pkg::GradW-1:0] wdata,
  input  logic                     re,
  input  logic [7:0]               x0,
  input  logic [7:0]               y0,
  output logic [gn2d_pkg::GradW-1:0] g00,
  output logic [gn2d_pkg::GradW-1:0] g10,
  output logic [gn2d_pkg::GradW-1:0] g01,
  output logic [gn2d_pkg::GradW-1:0] g11
);
  localparam int BankCols = GridW / 2 + 1;
  localparam int BankRows = GridH / 2 + 1;
  localparam int BankDepth = BankCols * BankRows;
  localparam int Aw = $clog2(BankDepth);
  localparam int Hw = 8;

  logic [gn2d_pkg::GradW-1:0] rd [4];
  logic [Aw-1:0] raddr [4];
  logic [Aw-1:0] waddr;
  logic [1:0] wbank;
  logic [Hw-1:0] wc, wr;
  logic [Hw-1:0] xp, yp;
  logic [1:0] sel;

  assign wc = {1'b0, wcol} >> 1;
  assign wr = {1'b0, wrow} >> 1;
  assign wbank = {wrow[0], wcol[0]};
  assign waddr = Aw'(wr * BankCols + wc);
  assign xp = x0 + 8'd1;
  assign yp = y0 + 8'd1;

  // Each bank (px, py) holds the corner whose column parity is px, row parity py.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] Bank = 2'(b);
    logic [Hw-1:0] cx, cy;
    assign cx = ((x0[0] == Bank[0]) ? x0 : xp) >> 1;
    assign cy = ((y0[0] == Bank[1]) ? y0 : yp) >> 1;
    assign raddr[b] = Aw'(cy * BankCols + cx);
    gn2d_ram #(.Width(gn2d_pkg::GradW), .Depth(BankDepth)) u_ram (
      .clk  (clk),
      .we   (we && (wbank == Bank)),
      .waddr(waddr),
      .wdata(wdata),
      .re   (re),
      .raddr(raddr[b]),
      .rdata(rd[b])
    );
  end

  // Remember the cell parity to route bank outputs back to corners.
  always_ff @(posedge clk) begin
    if (re) begin
      sel <= {y0[0], x0[0]};
    end
  end

  assign g00 = rd[{sel[1], sel[0]}];
  assign g10 = rd[{sel[1], ~sel[0]}];
  assign g01 = rd[{~sel[1], sel[0]}];
  assign g11 = rd[{~sel[1], ~sel[0]}];
endmodule

@@ rtl/core/gradient_noise_2d.sv @@
// Channel | Direction | Payload
// in      | input     | gn2d_pkg::in_item_t  (in_valid / in_ready)
// out     | output    | gn2d_pkg::out_item_t (out_valid / out_ready)
// One transaction per cycle; every transaction gives one result on out, in the order
// in which the transactions were accepted.
// Pipeline depth is set by the four-multiply fade chain and the two blend multiplies.
// The whole pipeline advances together; it stalls only when its last stage is full
// and out_ready is low. Reset clears the valid bits; the table is undefined until
// loaded, and a load is visible to any evaluate accepted after it.
module gradient_noise_2d #(
  parameter int GridW = gn2d_pkg::GridWDefault,
  parameter int GridH = gn2d_pkg::GridHDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gn2d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gn2d_pkg::out_item_t out_data
);
  localparam int Stages = 9;

  typedef struct packed {
    logic               eval;
    logic               inr;
    logic [15:0]        fx;
    logic [15:0]        fy;
  } ctl_t;

  logic en;
  logic [Stages-1:0] vld;
  ctl_t ctl [Stages];
  ctl_t ctl_in;
  logic is_eval, in_area, wr_ok;
  logic [gn2d_pkg::GradW-1:0] g00, g10, g01, g11;
  logic [16:0] sx, sy;

  assign en = !vld[Stages-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[Stages-1];

  // Input decode: range check of the point and of the load address.
  assign is_eval = (in_data.cmd == gn2d_pkg::CMD_EVAL);
  assign in_area = !in_data.coord_x[23] && !in_data.coord_y[23]
                   && (in_data.coord_x[22:16] < 7'(GridW) || GridW > 127)
                   && (in_data.coord_y[22:16] < 7'(GridH) || GridH > 127)
                   && ({1'b0, in_data.coord_x[22:16]} < 8'(GridW))
                   && ({1'b0, in_data.coord_y[22:16]} < 8'(GridH));
  assign wr_ok = !is_eval && ({1'b0, in_data.table_col} <= 8'(GridW))
                 && ({1'b0, in_data.table_row} <= 8'(GridH));
  assign ctl_in = '{eval: is_eval, inr: is_eval && in_area,
                    fx: in_data.coord_x[15:0], fy: in_data.coord_y[15:0]};

  // Valid and control shift line.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < Stages; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  gn2d_table #(.GridW(GridW), .GridH(GridH)) u_table (
    .clk  (clk),
    .we   (in_valid && en && wr_ok),
    .wcol (in_data.table_col),
    .wrow (in_data.table_row),
    .wdata({in_data.grad_y, in_data.grad_x}),
    .re   (en),
    .x0   ({1'b0, in_data.coord_x[22:16]}),
    .y0   ({1'b0, in_data.coord_y[22:16]}),
    .g00  (g00),
    .g10  (g10),
    .g01  (g01),
    .g11  (g11)
  );

  gn2d_fade u_fx (.clk(clk), .en(en), .f(ctl[0].fx), .s(sx));
  gn2d_fade u_fy (.clk(clk), .en(en), .f(ctl[0].fy), .s(sy));

  // Stage 1: corner dot products, Q.31.
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [33:0] n00, n10, n01, n11;
  assign dx0 = $signed({2'b00, ctl[0].fx});
  assign dy0 = $signed({2'b00, ctl[0].fy});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  function automatic logic signed [33:0] dot(input logic signed [17:0] dx,
                                             input logic signed [17:0] dy,
                                             input logic [31:0] g);
    logic signed [33:0] px, py;
    px = 34'(dx) * 34'($signed(g[15:0]));
    py = 34'(dy) * 34'($signed(g[31:16]));
    return px + py;
  endfunction

  logic signed [33:0] d00, d10, d01, d11;
  always_ff @(posedge clk) begin
    if (en) begin
      d00 <= dot(dx0, dy0, g00);
      d10 <= dot(dx1, dy0, g10);
      d01 <= dot(dx0, dy1, g01);
      d11 <= dot(dx1, dy1, g11);
    end
  end

  // Hold the dot products until the fade of x is ready for the x blend (stage 5).
  logic signed [33:0] h00 [3], h10 [3], h01 [3], h11 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      h00[0] <= d00; h10[0] <= d10; h01[0] <= d01; h11[0] <= d11;
      for (int i = 1; i < 3; i++) begin
        h00[i] <= h00[i-1]; h10[i] <= h10[i-1];
        h01[i] <= h01[i-1]; h11[i] <= h11[i-1];
      end
    end
  end
  assign n00 = h00[2];
  assign n10 = h10[2];
  assign n01 = h01[2];
  assign n11 = h11[2];

  // Stage 5: x blend products; stage 6: x blend sums. The y fade is delayed two
  // stages so that it meets the row sums.
  logic signed [52:0] m0, m1;
  logic signed [33:0] a0q, a1q;
  logic signed [34:0] row0, row1;
  logic [16:0] sy_d, sy_dd;
  always_ff @(posedge clk) begin
    if (en) begin
      m0    <= 53'(35'(n10) - 35'(n00)) * 53'($signed({1'b0, sx}));
      m1    <= 53'(35'(n11) - 35'(n01)) * 53'($signed({1'b0, sx}));
      a0q   <= n00;
      a1q   <= n01;
      row0  <= 35'(a0q) + 35'(m0 >>> 16);
      row1  <= 35'(a1q) + 35'(m1 >>> 16);
      sy_d  <= sy;
      sy_dd <= sy_d;
    end
  end

  // Stage 7: y blend product; stage 8: sum, scale and saturate.
  logic signed [54:0] my;
  logic signed [34:0] r0q;
  logic signed [35:0] vq;
  logic signed [20:0] vs;
  logic signed [17:0] sat;
  always_ff @(posedge clk) begin
    if (en) begin
      my  <= 55'(36'(row1) - 36'(row0)) * 55'($signed({1'b0, sy_dd}));
      r0q <= row0;
    end
  end
  assign vq = 36'(r0q) + 36'(my >>> 16);
  assign vs = 21'(vq >>> 15);
  assign sat = (vs > 21'sd131071) ? 18'sd131071 :
               (vs < -21'sd131072) ? -18'sd131072 : 18'(vs);

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.noise     <= ctl[Stages-2].inr ? sat : '0;
      out_data.in_range  <= ctl[Stages-2].inr;
      out_data.load_done <= !ctl[Stages-2].eval;
    end
  end
endmodule

@@ rtl/core/gn2d_checker.sv @@
// Port-level checker for the gradient noise block, bound to the top level.
// Depends on gn2d_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gn2d_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gn2d_pkg::out_item_t out_data
);
  // A stalled result holds its payload.
  `CHK_IMPL(a_out_hold, clk, rst, out_valid && !out_ready |=> $stable(out_data), "out held")
  // A result is either a load acknowledge or an evaluate, never both.
  `CHK_IMPL(a_kind, clk, rst, out_valid |-> !(out_data.load_done && out_data.in_range), "kind")
  // Loads and out-of-range points carry zero noise.
  `CHK_IMPL(a_zero, clk, rst, out_valid && !out_data.in_range |-> out_data.noise == '0, "zero")
  // Input is always taken when the output side drains.
  `CHK_IMPL(a_ready, clk, rst, out_ready |-> in_ready, "ready")
  // Nothing comes out right after a reset cycle.
  `CHK_ALWAYS(a_rst, clk, rst |=> !out_valid, "reset")
endmodule

bind gradient_noise_2d gn2d_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
